@@ rtl/all_to_all_round_robin_schedule_macros.svh @@
// assertion macros for the all-to-all round-robin schedule block
// used by the port checker; expects clk and rst in scope
`ifndef ALL_TO_ALL_ROUND_ROBIN_SCHEDULE_MACROS_SVH
`define ALL_TO_ALL_ROUND_ROBIN_SCHEDULE_MACROS_SVH

// same-cycle implication, disabled during reset
`define AARR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define AARR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aarr_pkg.sv @@
// shared types and constants for the all-to-all round-robin schedule block
// no dependencies
package aarr_pkg;

  localparam int SLOTS = 64;
  localparam int NODE_W = 6;
  localparam int CNT_W = 7;
  localparam int DEFAULT_MAX_NODES = 64;
  localparam int QUEUE_DEPTH = 2;

  // one request as it travels from the front end to the back end
  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [CNT_W-1:0]  node_count;
    logic [NODE_W-1:0] sort_node;
    logic              sort_enable;
    logic              ascending;
    logic              bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/aarr_front.sv @@
// front end: takes a request, checks node ids against the count
// depends on aarr_pkg
module aarr_front import aarr_pkg::*; #(
  parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [NODE_W-1:0] node_id,
  input  logic [CNT_W-1:0]  node_count,
  input  logic [NODE_W-1:0] sort_node,
  input  logic              sort_enable,
  input  logic              ascending,
  input  queue_status_t     qs,
  output logic              push,
  output job_t              job
);

  localparam int DEPTH = (MAX_NODES < SLOTS) ? MAX_NODES : SLOTS;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

  logic pending;
  job_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      if (start && !pending) begin
        pending <= 1'b1;
        held.node_id <= node_id;
        held.node_count <= node_count;
        held.sort_node <= sort_node;
        held.sort_enable <= sort_enable;
        held.ascending <= ascending;
        held.bad <= 1'b0;
      end else if (pending && !qs.full) begin
        pending <= 1'b0;
      end
    end
  end

  always_comb begin
    job = held;
    job.bad = (held.node_count == '0) || (held.node_count > LIMIT) ||
              ({1'b0, held.node_id} >= held.node_count) ||
              (held.sort_enable && ({1'b0, held.sort_node} >= held.node_count));
  end

  assign push = pending && !qs.full;
  assign busy = pending;

endmodule

@@ rtl/aarr_queue.sv @@
// short request queue between front end and back end
// depends on aarr_pkg
module aarr_queue import aarr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          din,
  input  logic          pop,
  output job_t          dout,
  output queue_status_t qs
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  job_t entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout = entries[rd_ptr];
  assign qs.full = (count == FULL_CNT);
  assign qs.empty = (count == '0);

endmodule

@@ rtl/aarr_back.sv @@
// back end: builds the schedule into the slot memory, then emits it
// depends on aarr_pkg
module aarr_back import aarr_pkg::*; #(
  parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     qs,
  input  job_t              head,
  output logic              pop,
  output logic              valid,
  output logic [NODE_W-1:0] partner,
  output logic [NODE_W-1:0] slot,
  output logic              last,
  output logic              error
);

  localparam int DEPTH = (MAX_NODES < SLOTS) ? MAX_NODES : SLOTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_EMIT} state_t;

  state_t state;
  job_t job;
  logic [NODE_W-1:0] k;
  logic [NODE_W-1:0] pe;
  logic [NODE_W-1:0] m;
  logic even;
  logic [NODE_W-1:0] v_own;
  logic [NODE_W-1:0] v_key;
  logic [NODE_W-1:0] rd_data;
  logic [NODE_W-1:0] mem [DEPTH];

  logic [NODE_W-1:0] m_init;
  logic [NODE_W-1:0] own_val;
  logic [NODE_W-1:0] key_val;
  logic [NODE_W-1:0] key_pos;
  logic [NODE_W-1:0] wr_addr;
  logic round;
  logic k_end;

  // partner of who in the current slot; v tracks 2*pe - who mod m
  function automatic logic [NODE_W-1:0] node_val(
    input logic              ev,
    input logic              k_zero,
    input logic [NODE_W-1:0] who,
    input logic [NODE_W-1:0] p,
    input logic [NODE_W-1:0] mm,
    input logic [NODE_W-1:0] v,
    input logic [CNT_W-1:0]  cnt
  );
    logic [NODE_W-1:0] r;
    if (!ev) begin
      r = v;
    end else if (k_zero) begin
      r = who;
    end else if (who == mm) begin
      r = p;
    end else if (p == who) begin
      r = NODE_W'(cnt - 1'b1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] step_v(
    input logic [NODE_W-1:0] v,
    input logic [NODE_W-1:0] mm
  );
    logic [NODE_W:0] s;
    s = {1'b0, v} + (NODE_W+1)'(2);
    if (s >= {1'b0, mm}) begin
      s = s - {1'b0, mm};
    end
    return s[NODE_W-1:0];
  endfunction

  assign pop = (state == S_IDLE) && !qs.empty;
  assign m_init = head.node_count[0] ? head.node_count[NODE_W-1:0]
                                     : NODE_W'(head.node_count - 1'b1);
  assign round = !even || (k != '0);
  assign k_end = ({1'b0, k} == job.node_count - 1'b1);

  always_comb begin
    own_val = node_val(even, k == '0, job.node_id, pe, m, v_own, job.node_count);
    key_val = node_val(even, k == '0, job.sort_node, pe, m, v_key, job.node_count);
    key_pos = job.ascending ? key_val
                            : NODE_W'(job.node_count - 1'b1 - {1'b0, key_val});
    wr_addr = job.sort_enable ? key_pos : k;
  end

  // slot memory: one write per fill cycle, one registered read per emit cycle
  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      mem[wr_addr[AW-1:0]] <= own_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      rd_data <= mem[k[AW-1:0]];
    end else begin
      rd_data <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            job <= head;
            k <= '0;
            pe <= '0;
            m <= m_init;
            even <= ~head.node_count[0];
            v_own <= (head.node_id == '0) ? '0 : m_init - head.node_id;
            v_key <= (head.sort_node == '0) ? '0 : m_init - head.sort_node;
            if (head.bad) begin
              valid <= 1'b1;
              error <= 1'b1;
              last <= 1'b1;
              slot <= '0;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (round) begin
            pe <= pe + 1'b1;
            v_own <= step_v(v_own, m);
            v_key <= step_v(v_key, m);
          end
          if (k_end) begin
            k <= '0;
            state <= S_EMIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          valid <= 1'b1;
          error <= 1'b0;
          slot <= k;
          last <= k_end;
          k <= k + 1'b1;
          if (k_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign partner = rd_data;

endmodule

@@ rtl/all_to_all_round_robin_schedule.sv @@
// top level of the all-to-all round-robin partner schedule generator
// depends on aarr_pkg, aarr_front, aarr_queue, aarr_back
//
// usage:
//   a request is taken at a rising edge where start is high and busy is low.
//   it names node_id, node_count N, and optionally a sort_node and direction.
//   the block answers with N results, one per slot, slot 0 first, each shown
//   for exactly one cycle with valid high; last marks slot N-1. a request
//   with a bad count or node id gives one result with error and last set,
//   partner and slot zero.
// timing:
//   busy goes high once a request is taken and stays high until it enters the
//   queue; a two-entry queue lets up to three requests wait while one is
//   worked on. for a valid request the back end first builds and permutes the
//   schedule into the slot memory (one slot per cycle, one memory write
//   port), then reads it out; an error request gives its result straight
//   from the idle state, with no build or read-out.
// reset:
//   rst clears the queue and both state machines; no result is shown in the
//   cycle after reset. results cannot be held off by the receiver.
module all_to_all_round_robin_schedule import aarr_pkg::*; #(
  parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [NODE_W-1:0] node_id,
  input  logic [CNT_W-1:0]  node_count,
  input  logic [NODE_W-1:0] sort_node,
  input  logic              sort_enable,
  input  logic              ascending,
  output logic              valid,
  output logic [NODE_W-1:0] partner,
  output logic [NODE_W-1:0] slot,
  output logic              last,
  output logic              error
);

  queue_status_t qs;
  logic push;
  logic pop;
  job_t front_job;
  job_t head;

  aarr_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .node_id(node_id),
    .node_count(node_count),
    .sort_node(sort_node),
    .sort_enable(sort_enable),
    .ascending(ascending),
    .qs(qs),
    .push(push),
    .job(front_job)
  );

  aarr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(front_job),
    .pop(pop),
    .dout(head),
    .qs(qs)
  );

  aarr_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk(clk),
    .rst(rst),
    .qs(qs),
    .head(head),
    .pop(pop),
    .valid(valid),
    .partner(partner),
    .slot(slot),
    .last(last),
    .error(error)
  );

endmodule

@@ rtl/aarr_checker.sv @@
// port-level checker for the all-to-all round-robin schedule block
// depends on aarr_pkg and all_to_all_round_robin_schedule_macros.svh
`include "all_to_all_round_robin_schedule_macros.svh"

module aarr_checker import aarr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic [NODE_W-1:0] partner,
  input logic [NODE_W-1:0] slot,
  input logic              last,
  input logic              error
);

  logic              sched;
  logic [NODE_W-1:0] slot_inc;

  // a result that belongs to a schedule, not an error item
  assign sched = valid && !error;
  assign slot_inc = slot + 1'b1;

  // an error item is a single zero result
  `AARR_ASSERT_NOW(a_err_shape, valid && error, last && (partner | slot) == '0, "bad error item")

  // slots of one schedule come out back to back in order
  `AARR_ASSERT_NEXT(a_slot_seq, sched && !last, sched && slot == $past(slot_inc), "bad slot order")

  // a schedule is never followed at once by the next schedule
  `AARR_ASSERT_NEXT(a_gap_after_last, sched && last, !sched, "no gap after last slot")

  // nothing is shown right after reset
  `AARR_ASSERT_NOW(a_quiet_after_rst, $past(rst), !valid, "result right after reset")

endmodule

bind all_to_all_round_robin_schedule aarr_checker u_aarr_checker (.*);

@@ sim/tb_all_to_all_round_robin_schedule.sv @@
`timescale 1ns / 1ps
// self-checking testbench for all_to_all_round_robin_schedule: directed and random requests
// with every emitted slot checked against a local round-robin timetable predictor
// depends on aarr_pkg and the rtl top level
module tb_all_to_all_round_robin_schedule;
  import aarr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_REQUESTS = 90;
  localparam int NODE_LIMIT = (DEFAULT_MAX_NODES < SLOTS) ? DEFAULT_MAX_NODES : SLOTS;

  typedef logic [SLOTS-1:0][NODE_W-1:0] timetable_t;

  typedef struct packed {
    logic [NODE_W-1:0] partner;
    logic [NODE_W-1:0] slot;
    logic              last;
    logic              error;
  } slot_entry_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [NODE_W-1:0] node_id = '0;
  logic [CNT_W-1:0]  node_count = '0;
  logic [NODE_W-1:0] sort_node = '0;
  logic              sort_enable = 1'b0;
  logic              ascending = 1'b0;
  logic              busy;
  logic              valid;
  logic [NODE_W-1:0] partner;
  logic [NODE_W-1:0] slot;
  logic              last;
  logic              error;

  slot_entry_t due_slots[$];
  int cycle_count = 0;
  int mismatches = 0;
  int slots_checked = 0;
  int requests_sent = 0;
  int rejected_requests = 0;
  int burst_left = 0;

  all_to_all_round_robin_schedule u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .node_id(node_id),
    .node_count(node_count),
    .sort_node(sort_node),
    .sort_enable(sort_enable),
    .ascending(ascending),
    .valid(valid),
    .partner(partner),
    .slot(slot),
    .last(last),
    .error(error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // partner list of one node in the round-robin timetable of cnt nodes
  function automatic timetable_t round_robin_row(int who, int cnt);
    timetable_t row;
    int picks[$];
    int n;
    int m;
    int i;
    int v;
    bit even;
    row = '0;
    even = (cnt % 2) == 0;
    n = even ? cnt : cnt + 1;
    m = n - 1;
    if (even) picks.push_back(who);
    for (int pe = 0; pe < m; pe++) begin
      if (even) begin
        if (pe == who) picks.push_back(cnt - 1);
        else if (cnt - 1 == who) picks.push_back(pe);
      end else if (pe == who) begin
        // odd count: meet yourself where the phantom node would be
        picks.push_back(pe);
      end
      if (pe != who && who < m) begin
        i = (pe + m - who) % m;
        if (i < n / 2) picks.push_back((pe + i) % m);
        i = (who + m - pe) % m;
        if (i < n / 2) picks.push_back((pe + m - i) % m);
      end
    end
    for (int k = 0; k < picks.size() && k < SLOTS; k++) begin
      v = picks[k];
      row[k] = v[NODE_W-1:0];
    end
    return row;
  endfunction

  // queue up the slots one accepted request must produce
  function automatic void plan_schedule(int who, int cnt, int sorter, bit sort_on, bit asc);
    timetable_t own;
    timetable_t key;
    timetable_t order;
    slot_entry_t e;
    int pos;
    if (cnt == 0 || cnt > NODE_LIMIT || who >= cnt || (sort_on && sorter >= cnt)) begin
      e.partner = '0;
      e.slot = '0;
      e.last = 1'b1;
      e.error = 1'b1;
      due_slots.push_back(e);
      rejected_requests++;
      return;
    end
    own = round_robin_row(who, cnt);
    order = own;
    if (sort_on) begin
      order = '0;
      key = round_robin_row(sorter, cnt);
      for (int k = 0; k < cnt; k++) begin
        pos = key[k];
        if (pos < cnt) begin
          if (!asc) pos = cnt - 1 - pos;
          order[pos] = own[k];
        end
      end
    end
    for (int k = 0; k < cnt; k++) begin
      e.partner = order[k];
      e.slot = k[NODE_W-1:0];
      e.last = (k == cnt - 1);
      e.error = 1'b0;
      due_slots.push_back(e);
    end
  endfunction

  // sender idles in bursts; start stays high across back-to-back items
  task automatic send_request(int who, int cnt, int sorter, bit sort_on, bit asc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    node_id <= who[NODE_W-1:0];
    node_count <= cnt[CNT_W-1:0];
    sort_node <= sorter[NODE_W-1:0];
    sort_enable <= sort_on;
    ascending <= asc;
    @(posedge clk);
    while (busy) @(posedge clk);
    plan_schedule(who, cnt, sorter, sort_on, asc);
    requests_sent++;
  endtask

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  always @(posedge clk) begin : check_slots
    slot_entry_t want;
    if (!rst && valid) begin
      slots_checked++;
      if (due_slots.size() == 0) begin
        flag_mismatch($sformatf("unexpected item partner %0d slot %0d last %0b error %0b",
                                partner, slot, last, error));
      end else begin
        want = due_slots.pop_front();
        if (partner !== want.partner || slot !== want.slot ||
            last !== want.last || error !== want.error)
          flag_mismatch($sformatf(
            "expected partner %0d slot %0d last %0b error %0b, got %0d %0d %0b %0b",
            want.partner, want.slot, want.last, want.error,
            partner, slot, last, error));
      end
    end
  end

  task automatic test_schedule_shapes();
    send_request(0, 1, 0, 0, 0);
    send_request(1, 2, 0, 0, 1);
    send_request(2, 3, 0, 0, 0);
    send_request(3, 4, 63, 0, 1);
    send_request(62, 63, 0, 0, 0);
    send_request(0, 64, 0, 0, 0);
    send_request(63, 64, 21, 0, 1);
  endtask

  task automatic test_reordering();
    send_request(2, 5, 0, 1, 1);
    send_request(2, 5, 4, 1, 0);
    send_request(3, 6, 3, 1, 1);
    send_request(0, 64, 63, 1, 1);
    send_request(63, 64, 0, 1, 0);
    send_request(0, 1, 0, 1, 0);
  endtask

  task automatic test_bad_requests();
    send_request(5, 5, 0, 0, 0);
    send_request(63, 63, 0, 0, 1);
    send_request(1, 4, 4, 1, 1);
    send_request(1, 4, 63, 0, 1);
    send_request(0, 0, 0, 0, 0);
    send_request(0, 65, 0, 0, 0);
    send_request(63, 127, 63, 1, 1);
  endtask

  // mostly small well-formed requests, a few large ones, some noise
  task automatic test_random_traffic();
    int mode;
    int cnt;
    for (int r = 0; r < RANDOM_REQUESTS; r++) begin
      mode = $urandom_range(0, 99);
      if (mode < 12) begin
        send_request($urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        cnt = (mode < 24) ? $urandom_range(33, 64) : $urandom_range(1, 16);
        send_request($urandom_range(0, cnt - 1), cnt,
                     (mode < 30) ? $urandom_range(0, 63) : $urandom_range(0, cnt - 1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout with %0d slots still due", due_slots.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_schedule_shapes();
    test_reordering();
    test_bad_requests();
    test_random_traffic();
    start <= 1'b0;
    while (due_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += due_slots.size();
    $display("covered %0d requests (%0d rejected), %0d slot results checked, %0d mismatches",
             requests_sent, rejected_requests, slots_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/aarr_pkg.sv
rtl/aarr_front.sv
rtl/aarr_queue.sv
rtl/aarr_back.sv
rtl/all_to_all_round_robin_schedule.sv
rtl/aarr_checker.sv
sim/tb_all_to_all_round_robin_schedule.sv
